// ===== hw/rtl/dual_load_cell_weight_flow_filter_core_macros.svh =====
// Assertion macros shared by the checker of the load cell filter.
// Depends on nothing; included by the checker file.
`ifndef DUAL_LOAD_CELL_WEIGHT_FLOW_FILTER_CORE_MACROS_SVH
`define DUAL_LOAD_CELL_WEIGHT_FLOW_FILTER_CORE_MACROS_SVH
// implication checked on every edge outside reset
`define LCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcf check failed");
// implication whose consequence is checked on the next edge
`define LCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcf check failed");
`endif

// ===== hw/rtl/lcf_pkg.sv =====
// Shared types, constants and helpers of the load cell filter.
// No dependencies.
`default_nettype none
package lcf_pkg;
	localparam int SAMPLE_BITS = 24;
	localparam logic [16:0] ALPHA_W = 17'd19661;
	localparam logic [16:0] ALPHA_F = 17'd9830;
	localparam logic signed [31:0] DEADBAND = 32'sd3276;
	localparam logic [19:0] US_PER_S = 20'd1000000;

	localparam logic [2:0] REG_ZERO_A = 3'd0;
	localparam logic [2:0] REG_ZERO_B = 3'd1;
	localparam logic [2:0] REG_GAIN_A = 3'd2;
	localparam logic [2:0] REG_GAIN_B = 3'd3;
	localparam logic [2:0] REG_INTERVAL = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MED, ST_GAIN_HI, ST_GAIN_LO, ST_WEIGHT, ST_EMA_X, ST_EMA_E,
		ST_EMA_DONE, ST_FLOW_MUL, ST_DIV, ST_FLOW_FIN, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;     // capture request, accumulate time
		logic med;      // write history, take medians
		logic gain_hi;  // high gain partial products
		logic gain_lo;  // low gain partial products, finish weights
		logic sum;      // form weight sum
		logic ema_x;    // alpha * x for lane
		logic ema_e;    // (1-alpha) * e for lane
		logic ema_done; // round and store lane
		logic [1:0] lane; // 0 a,1 b,2 sum,3 flow
		logic flow_mul; // magnitude * 1e6, start divide
		logic div_step; // one quotient bit
		logic flow_fin; // deadband, update flow state
		logic out_load; // load output register
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic flow_due;
		logic div_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] med3(
		input logic signed [SAMPLE_BITS-1:0] a, b, c);
		logic signed [SAMPLE_BITS-1:0] lo, hi, m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/lcf_ctrl.sv =====
// Sequencer of the load cell filter: steps the datapath through one request.
// Depends on lcf_pkg.
`default_nettype none
module lcf_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_go,
	input  wire logic out_busy,
	input  wire lcf_pkg::sts_t sts,
	output lcf_pkg::cmd_t cmd,
	output logic idle
);
	import lcf_pkg::*;
	state_t state_q, state_d;
	logic [1:0] lane_q, lane_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q <= 2'd0;
		end else begin
			state_q <= state_d;
			lane_q <= lane_d;
		end
	end

	always_comb begin
		state_d = state_q;
		lane_d = lane_q;
		cmd = '0;
		cmd.lane = lane_q;
		idle = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_go) begin
					cmd.load = 1'b1;
					state_d = ST_MED;
				end
			end
			ST_MED: begin
				if (sts.ok) begin
					cmd.med = 1'b1;
					state_d = ST_GAIN_HI;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_GAIN_HI: begin
				cmd.gain_hi = 1'b1;
				state_d = ST_GAIN_LO;
			end
			ST_GAIN_LO: begin
				cmd.gain_lo = 1'b1;
				state_d = ST_WEIGHT;
			end
			ST_WEIGHT: begin
				cmd.sum = 1'b1;
				lane_d = 2'd0;
				state_d = ST_EMA_X;
			end
			ST_EMA_X: begin
				cmd.ema_x = 1'b1;
				state_d = ST_EMA_E;
			end
			ST_EMA_E: begin
				cmd.ema_e = 1'b1;
				state_d = ST_EMA_DONE;
			end
			ST_EMA_DONE: begin
				cmd.ema_done = 1'b1;
				if (lane_q == 2'd3) begin
					state_d = ST_FLOW_FIN;
				end else if (lane_q == 2'd2) begin
					state_d = sts.flow_due ? ST_FLOW_MUL : ST_OUT;
				end else begin
					lane_d = lane_q + 2'd1;
					state_d = ST_EMA_X;
				end
			end
			ST_FLOW_MUL: begin
				cmd.flow_mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					lane_d = 2'd3;
					state_d = ST_EMA_X;
				end
			end
			ST_FLOW_FIN: begin
				cmd.flow_fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lcf_dp.sv =====
// Datapath of the load cell filter: history, weights, EMAs, serial divider.
// Depends on lcf_pkg.
`default_nettype none
module lcf_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire lcf_pkg::cmd_t cmd,
	output lcf_pkg::sts_t sts,
	input  wire logic signed [lcf_pkg::SAMPLE_BITS-1:0] in_a,
	input  wire logic signed [lcf_pkg::SAMPLE_BITS-1:0] in_b,
	input  wire logic in_ok,
	input  wire logic [19:0] in_dt,
	input  wire logic signed [23:0] zero_a,
	input  wire logic signed [23:0] zero_b,
	input  wire logic [31:0] gain_a,
	input  wire logic [31:0] gain_b,
	input  wire logic [19:0] interval,
	output logic signed [31:0] ema_a,
	output logic signed [31:0] ema_b,
	output logic signed [31:0] ema_sum,
	output logic signed [31:0] flow,
	output logic updated
);
	import lcf_pkg::*;
	localparam int SB = SAMPLE_BITS;

	logic signed [SB-1:0] hist_a_q [3];
	logic signed [SB-1:0] hist_b_q [3];
	logic [1:0] slot_q;
	logic signed [SB-1:0] smp_a_q, smp_b_q;
	logic ok_q, upd_q;
	logic [31:0] tsf_q;
	logic signed [31:0] ema_q [4];
	logic signed [31:0] last_q;
	logic neg_a_q, neg_b_q;
	logic [SB:0] mag_a_q, mag_b_q;
	logic [SB+16:0] hi_a_q, hi_b_q;
	logic signed [31:0] w_q [3];
	logic signed [63:0] acc_q;
	logic signed [49:0] prod_q;
	logic fneg_q;
	logic [52:0] num_q;
	logic [52:0] rem_q;
	logic [5:0] cnt_q;
	logic [32:0] quo_q;
	logic signed [31:0] raw_q;

	logic [32:0] tsum;
	logic [31:0] tsf_new;
	logic signed [SB-1:0] cand_a [3];
	logic signed [SB-1:0] cand_b [3];
	logic signed [SB:0] diff_a, diff_b;
	logic [SB+16:0] lo_a, lo_b, r_a, r_b;
	logic signed [31:0] x_sel, e_sel;
	logic [16:0] alpha;
	logic signed [63:0] acc_fin;
	logic signed [31:0] ema_new;
	logic signed [32:0] dw;
	logic [32:0] dw_mag;
	logic [53:0] rem_try;
	logic [19:0] ivl;

	// quotient saturated to 2^32 once it leaves 33 bits
	function automatic logic [32:0] q_sat(input logic [32:0] q, input logic b);
		if (q[32]) return 33'h100000000;
		return {q[31:0], b};
	endfunction

	assign tsum = {1'b0, tsf_q} + {13'd0, in_dt};
	assign tsf_new = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
	assign ivl = (interval == 20'd0) ? 20'd1 : interval;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cand_a[i] = (slot_q == i[1:0]) ? smp_a_q : hist_a_q[i];
			cand_b[i] = (slot_q == i[1:0]) ? smp_b_q : hist_b_q[i];
		end
	end
	assign diff_a = SB'(med3(cand_a[0], cand_a[1], cand_a[2])) - (SB+1)'(zero_a);
	assign diff_b = SB'(med3(cand_b[0], cand_b[1], cand_b[2])) - (SB+1)'(zero_b);

	assign lo_a = (SB+17)'(mag_a_q * gain_a[15:0]);
	assign lo_b = (SB+17)'(mag_b_q * gain_b[15:0]);
	assign r_a = hi_a_q + ((lo_a + (neg_a_q ? (SB+17)'(32767) : (SB+17)'(32768))) >> 16);
	assign r_b = hi_b_q + ((lo_b + (neg_b_q ? (SB+17)'(32767) : (SB+17)'(32768))) >> 16);

	always_comb begin
		case (cmd.lane)
			2'd0: x_sel = w_q[0];
			2'd1: x_sel = w_q[1];
			2'd2: x_sel = w_q[2];
			default: x_sel = raw_q;
		endcase
		e_sel = ema_q[cmd.lane];
		alpha = (cmd.lane == 2'd3) ? ALPHA_F : ALPHA_W;
	end
	assign acc_fin = acc_q + 64'sd32768;
	assign ema_new = sat32(acc_fin >>> 16);

	assign dw = 33'(ema_q[2]) - 33'(last_q);
	assign dw_mag = dw[32] ? 33'(-dw) : 33'(dw);
	assign rem_try = {rem_q, num_q[52]} - {22'd0, tsf_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				hist_a_q[i] <= '0;
				hist_b_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) ema_q[i] <= '0;
			slot_q <= '0;
			tsf_q <= '0;
			last_q <= '0;
			ok_q <= 1'b0;
			upd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				smp_a_q <= in_a;
				smp_b_q <= in_b;
				ok_q <= in_ok;
				upd_q <= 1'b0;
				tsf_q <= tsf_new;
			end
			if (cmd.med) begin
				hist_a_q[slot_q] <= smp_a_q;
				hist_b_q[slot_q] <= smp_b_q;
				slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
				neg_a_q <= diff_a[SB];
				neg_b_q <= diff_b[SB];
				mag_a_q <= diff_a[SB] ? (SB+1)'(-diff_a) : (SB+1)'(diff_a);
				mag_b_q <= diff_b[SB] ? (SB+1)'(-diff_b) : (SB+1)'(diff_b);
			end
			if (cmd.gain_hi) begin
				hi_a_q <= (SB+17)'(mag_a_q * gain_a[31:16]);
				hi_b_q <= (SB+17)'(mag_b_q * gain_b[31:16]);
			end
			if (cmd.gain_lo) begin
				w_q[0] <= sat32(neg_a_q ? -64'(r_a) : 64'(r_a));
				w_q[1] <= sat32(neg_b_q ? -64'(r_b) : 64'(r_b));
			end
			if (cmd.sum) w_q[2] <= sat32(64'(w_q[0]) + 64'(w_q[1]));
			if (cmd.ema_x) begin
				prod_q <= 50'($signed({1'b0, alpha}) * x_sel);
			end
			if (cmd.ema_e) begin
				acc_q <= 64'(prod_q) + 64'($signed(17'h10000 - {1'b0, alpha[15:0]}) * e_sel);
			end
			if (cmd.ema_done && cmd.lane != 2'd3) ema_q[cmd.lane] <= ema_new;
			if (cmd.flow_mul) begin
				fneg_q <= dw[32];
				num_q <= 53'(dw_mag * US_PER_S) + 53'(tsf_q >> 1);
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'd53;
			end
			if (cmd.div_step && cnt_q != 6'd0) begin
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 6'd1;
				if (!rem_try[53]) begin
					rem_q <= rem_try[52:0];
					quo_q <= (quo_q[32] ? quo_q : {quo_q[31:0], 1'b1});
				end else begin
					rem_q <= {rem_q[51:0], num_q[52]};
					quo_q <= (quo_q[32] ? quo_q : {quo_q[31:0], 1'b0});
				end
				if (cnt_q == 6'd1) begin
					raw_q <= sat32(fneg_q ? -64'(q_sat(quo_q, !rem_try[53]))
						: 64'(q_sat(quo_q, !rem_try[53])));
				end
			end
			if (cmd.flow_fin) begin
				ema_q[3] <= (ema_new >= -DEADBAND && ema_new <= DEADBAND) ? '0 : ema_new;
				last_q <= ema_q[2];
				tsf_q <= '0;
				upd_q <= 1'b1;
			end
		end
	end

	assign sts.ok = ok_q;
	assign sts.flow_due = (tsf_q >= {12'd0, ivl});
	assign sts.div_done = (cnt_q == 6'd1);
	assign ema_a = ema_q[0];
	assign ema_b = ema_q[1];
	assign ema_sum = ema_q[2];
	assign flow = ema_q[3];
	assign updated = upd_q;
endmodule
`default_nettype wire

// ===== hw/rtl/dual_load_cell_weight_flow_filter_core.sv =====
// Top level of the dual load cell weight and flow filter.
// Depends on lcf_pkg, lcf_ctrl, lcf_dp.
//
// Usage:
//  - Input channel (valid/stall): one request carries sample_a, sample_b,
//    read_ok and delta_us. Output channel (valid/stall): one result per
//    request with the four filtered Q16.16 values and two flags.
//  - Configuration: write cfg_we with cfg_index/cfg_data while idle.
//  - One request at a time. A good read with a flow update due runs the
//    gain, weight EMA, restoring divider and flow EMA steps before its
//    result is loaded; the next request is taken once the sequencer is idle.
//    A good read without a flow update skips the divider and flow EMA.
//    A failed read goes straight from the read check to the output load.
//  - The EMA lanes share one multiply pair and are worked one lane at a time.
//  - Result sits in an output register; a new request is taken while it
//    waits, and the sequencer holds before its output load if it is full.
//  - A stalled result holds its value until taken.
//  - Reset clears history, filter state, time accumulator and loads the
//    default calibration; out_valid drops.
//
`default_nettype none
module dual_load_cell_weight_flow_filter_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [lcf_pkg::SAMPLE_BITS-1:0] sample_a,
	input  wire logic signed [lcf_pkg::SAMPLE_BITS-1:0] sample_b,
	input  wire logic read_ok,
	input  wire logic [19:0] delta_us,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [31:0] weight_a,
	output logic signed [31:0] weight_b,
	output logic signed [31:0] weight_sum,
	output logic signed [31:0] flow_rate,
	output logic flow_updated,
	output logic sample_used,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	import lcf_pkg::*;
	logic signed [23:0] zero_a_q, zero_b_q;
	logic [31:0] gain_a_q, gain_b_q;
	logic [19:0] ivl_q;
	cmd_t cmd;
	sts_t sts;
	logic idle;
	logic signed [31:0] ea, eb, es, fl;
	logic upd;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_a_q <= 24'sd14450;
			zero_b_q <= 24'sd56000;
			gain_a_q <= 32'd3999299;
			gain_b_q <= 32'd3858910;
			ivl_q <= 20'd100000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_A: zero_a_q <= cfg_data[23:0];
				REG_ZERO_B: zero_b_q <= cfg_data[23:0];
				REG_GAIN_A: gain_a_q <= cfg_data;
				REG_GAIN_B: gain_b_q <= cfg_data;
				REG_INTERVAL: ivl_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	assign in_stall = !idle;

	lcf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_valid), .out_busy(out_valid && out_stall),
		.sts(sts), .cmd(cmd), .idle(idle)
	);

	lcf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_a(sample_a), .in_b(sample_b), .in_ok(read_ok), .in_dt(delta_us),
		.zero_a(zero_a_q), .zero_b(zero_b_q), .gain_a(gain_a_q), .gain_b(gain_b_q),
		.interval(ivl_q), .ema_a(ea), .ema_b(eb), .ema_sum(es), .flow(fl),
		.updated(upd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			weight_a <= ea;
			weight_b <= eb;
			weight_sum <= es;
			flow_rate <= fl;
			flow_updated <= upd;
			sample_used <= sts.ok;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lcf_checker.sv =====
// Port-level checker for the load cell filter, bound to the top level.
// Depends on the macros header.
`default_nettype none
`include "dual_load_cell_weight_flow_filter_core_macros.svh"
module lcf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic flow_updated,
	input wire logic sample_used,
	input wire logic signed [31:0] flow_rate
);
	`LCF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`LCF_ASSERT_IMPL(a_upd_used, clk, arst_n, out_valid && flow_updated, sample_used)
	`LCF_ASSERT_NEXT(a_one_req, clk, arst_n, in_valid && !in_stall, in_stall)
	`LCF_ASSERT_IMPL(a_deadband, clk, arst_n, out_valid && flow_updated,
		flow_rate == 32'sd0 || flow_rate > 32'sd3276 || flow_rate < -32'sd3276)
endmodule
bind dual_load_cell_weight_flow_filter_core lcf_checker u_lcf_checker (.*);
`default_nettype wire
